// ===== design/selective_repeat_sender_window_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Check a property on every rising aclk edge outside of reset.
`define SRSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define SRSW_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== design/srsw_pkg.sv =====
package srsw_pkg;

    localparam int SEQ_SPACE_DEF = 16;

    // window bookkeeping width, window never exceeds WIN_MAX slots
    localparam int CNT_W   = 4;
    localparam int WIN_MAX = 8;
    localparam logic [CNT_W-1:0] WIN_RESET = 4'd8;

    // slot states
    localparam logic [1:0] ST_UNSENT = 2'd0;
    localparam logic [1:0] ST_SENT   = 2'd1;
    localparam logic [1:0] ST_CONF   = 2'd2;

    // input modes
    localparam logic [1:0] MODE_SUBMIT = 2'd0;
    localparam logic [1:0] MODE_REPLY  = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    // result actions
    localparam logic [1:0] ACT_STATUS = 2'd0;
    localparam logic [1:0] ACT_XMIT   = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] action;
        logic [3:0] seq_num;
        logic       accepted;
        logic [3:0] assigned;
        logic [3:0] outstanding;
        logic       last;
    } rslt_t;

endpackage

// ===== design/srsw_slot_mem.sv =====
module srsw_slot_mem #(
    parameter int DEPTH  = srsw_pkg::SEQ_SPACE_DEF,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [1:0]        wr_data,
    input  logic              re,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [1:0]        rd_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/srsw_mod_unit.sv =====
module srsw_mod_unit #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF,
    parameter int ADDR_W    = 4
) (
    input  logic [ADDR_W-1:0] x,
    input  logic [ADDR_W-1:0] base,
    output logic [ADDR_W-1:0] offs,
    output logic [ADDR_W-1:0] nxt
);

    logic [ADDR_W:0] diff;
    logic [ADDR_W:0] wrapped;

    // distance from base modulo the sequence space
    assign diff    = {1'b0, x} - {1'b0, base};
    assign wrapped = diff + (ADDR_W+1)'(SEQ_SPACE);
    assign offs    = diff[ADDR_W] ? wrapped[ADDR_W-1:0] : diff[ADDR_W-1:0];

    // successor with wrap at the end of the sequence space
    assign nxt = (x == ADDR_W'(SEQ_SPACE - 1)) ? '0 : x + 1'b1;

endmodule

// ===== design/srsw_ctrl.sv =====
module srsw_ctrl #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF,
    parameter int ADDR_W    = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_mode,
    input  logic [3:0]                    in_seq,
    input  logic                          in_ack,
    input  logic [srsw_pkg::CNT_W-1:0]    win_cfg,
    output srsw_pkg::rslt_t               push,
    input  logic                          out_free,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_wr_addr,
    output logic [1:0]                    mem_wr_data,
    output logic                          mem_re,
    output logic [ADDR_W-1:0]             mem_rd_addr,
    input  logic [1:0]                    mem_rd_data,
    output logic [ADDR_W-1:0]             mu_x,
    output logic [ADDR_W-1:0]             mu_base,
    input  logic [ADDR_W-1:0]             mu_dist,
    input  logic [ADDR_W-1:0]             mu_nxt
);

    import srsw_pkg::*;

    localparam int WIN_CAP_I = (SEQ_SPACE / 2 < WIN_MAX) ? SEQ_SPACE / 2 : WIN_MAX;
    localparam logic [CNT_W-1:0] WIN_CAP = CNT_W'(WIN_CAP_I);
    localparam int CMP_W = ADDR_W + CNT_W;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_EVT       = 8'b0000_0010,
        S_EVT_CHK   = 8'b0000_0100,
        S_SLIDE_RD  = 8'b0000_1000,
        S_SLIDE_CHK = 8'b0001_0000,
        S_SWEEP_RD  = 8'b0010_0000,
        S_SWEEP_CHK = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  win_reg, win_next;
    logic [1:0]        mode_reg, mode_next;
    logic [3:0]        seq_reg, seq_next;
    logic              ack_reg, ack_next;
    logic              accepted_reg, accepted_next;
    logic [3:0]        assigned_reg, assigned_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [1:0]        pend_act_reg, pend_act_next;
    logic [3:0]        pend_seq_reg, pend_seq_next;

    logic [ADDR_W-1:0] seq_addr;
    logic              seq_ok;

    assign seq_addr = ADDR_W'(seq_reg);
    assign seq_ok   = int'(seq_reg) < SEQ_SPACE;
    assign mu_base  = base_reg;

    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        base_next       = base_reg;
        ptr_next        = ptr_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        win_next        = win_reg;
        mode_next       = mode_reg;
        seq_next        = seq_reg;
        ack_next        = ack_reg;
        accepted_next   = accepted_reg;
        assigned_next   = assigned_reg;
        pend_valid_next = pend_valid_reg;
        pend_act_next   = pend_act_reg;
        pend_seq_next   = pend_seq_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_wr_addr     = ptr_reg;
        mem_wr_data     = ST_SENT;
        mem_re          = 1'b0;
        mem_rd_addr     = ptr_reg;
        mu_x            = ptr_reg;
        push            = '0;
        push.accepted   = accepted_reg;
        push.assigned   = assigned_reg;
        push.outstanding = count_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    mode_next       = in_mode;
                    seq_next        = in_seq;
                    ack_next        = in_ack;
                    win_next        = (win_cfg > WIN_CAP) ? WIN_CAP : win_cfg;
                    accepted_next   = 1'b0;
                    assigned_next   = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_EVT;
                end
            end
            S_EVT: begin
                steps_next = '0;
                state_next = S_SLIDE_RD;
                if (mode_reg == MODE_SUBMIT) begin
                    mu_x = cursor_reg;
                    if (fill_reg < win_reg) begin
                        mem_we        = 1'b1;
                        mem_wr_addr   = cursor_reg;
                        mem_wr_data   = ST_UNSENT;
                        accepted_next = 1'b1;
                        assigned_next = 4'(cursor_reg);
                        cursor_next   = mu_nxt;
                        count_next    = count_reg + 1'b1;
                        fill_next     = fill_reg + 1'b1;
                    end
                end else begin
                    mu_x = seq_addr;
                    // only written slots inside the window can be in flight
                    if ((mode_reg == MODE_REPLY || mode_reg == MODE_EXPIRE) && seq_ok &&
                        (CMP_W'(mu_dist) < CMP_W'(fill_reg))) begin
                        mem_re      = 1'b1;
                        mem_rd_addr = seq_addr;
                        state_next  = S_EVT_CHK;
                    end
                end
            end
            S_EVT_CHK: begin
                state_next = S_SLIDE_RD;
                if (mem_rd_data == ST_SENT) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = seq_addr;
                    mem_wr_data = ST_UNSENT;
                    if (mode_reg == MODE_REPLY) begin
                        pend_valid_next = 1'b1;
                        pend_act_next   = ACT_STOP;
                        pend_seq_next   = seq_reg;
                        if (ack_reg) begin
                            mem_wr_data = ST_CONF;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end
            end
            S_SLIDE_RD: begin
                if (steps_reg < win_reg && fill_reg != '0) begin
                    mem_re      = 1'b1;
                    mem_rd_addr = base_reg;
                    state_next  = S_SLIDE_CHK;
                end else begin
                    ptr_next   = base_reg;
                    steps_next = '0;
                    state_next = S_SWEEP_RD;
                end
            end
            S_SLIDE_CHK: begin
                mu_x = base_reg;
                if (mem_rd_data == ST_CONF) begin
                    base_next  = mu_nxt;
                    fill_next  = fill_reg - 1'b1;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_SLIDE_RD;
                end else begin
                    ptr_next   = base_reg;
                    steps_next = '0;
                    state_next = S_SWEEP_RD;
                end
            end
            S_SWEEP_RD: begin
                if (steps_reg < win_reg && steps_reg < fill_reg) begin
                    mem_re     = 1'b1;
                    state_next = S_SWEEP_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SWEEP_CHK: begin
                if (mem_rd_data == ST_UNSENT) begin
                    // hold while the previous result cannot be handed on
                    if (!pend_valid_reg || out_free) begin
                        mem_we          = 1'b1;
                        push.valid      = pend_valid_reg;
                        push.action     = pend_act_reg;
                        push.seq_num    = pend_seq_reg;
                        pend_valid_next = 1'b1;
                        pend_act_next   = ACT_XMIT;
                        pend_seq_next   = 4'(ptr_reg);
                        ptr_next        = mu_nxt;
                        steps_next      = steps_reg + 1'b1;
                        state_next      = S_SWEEP_RD;
                    end
                end else begin
                    ptr_next   = mu_nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_SWEEP_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    push.valid   = 1'b1;
                    push.last    = 1'b1;
                    push.action  = pend_valid_reg ? pend_act_reg : ACT_STATUS;
                    push.seq_num = pend_valid_reg ? pend_seq_reg : 4'd0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            base_reg       <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            base_reg       <= base_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        steps_reg    <= steps_next;
        win_reg      <= win_next;
        mode_reg     <= mode_next;
        seq_reg      <= seq_next;
        ack_reg      <= ack_next;
        accepted_reg <= accepted_next;
        assigned_reg <= assigned_next;
        pend_act_reg <= pend_act_next;
        pend_seq_reg <= pend_seq_next;
    end

endmodule

// ===== design/selective_repeat_sender_window.sv =====
// Selective-repeat ARQ sender window. Each input word is a submit, a receiver
// reply (ACK/NACK) or a timer expiry; the block updates the per-sequence slot
// states, slides the window base over confirmed slots and then sweeps the
// window, emitting one transmit command per unsent slot. A reply to a sent
// slot first yields a stop-timer command. Every input word yields at least one
// result word, the final one flagged by m_tlast; an input that causes no
// command yields a single status word. An accepted input word keeps s_tready
// low until its final result word is loaded into the output register. Slot
// states sit in the single slot-state memory, which is read once per slot
// visited, and one shared modular step unit gives distances and successors.
// The block stalls only while m_tready holds off a result. s_tready is high
// only between items. No clearing pass runs after reset: only slots written
// since reset are ever looked at. window_size is taken from cfg_wdata on
// cfg_we, clamped to 8 and to SEQ_SPACE/2, and is sampled when an input word
// is accepted.
`include "selective_repeat_sender_window_macros.svh"

module selective_repeat_sender_window #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,   // window_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [3:0] seq_num, [7:4] zero
    input  logic [2:0]  s_tuser,     // [1:0] mode, [2] is_ack
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [3:0] seq_num_out, [4] accepted,
                                     // [8:5] assigned_seq, [12:9] outstanding,
                                     // [15:13] zero
    output logic [1:0]  m_tuser,     // [1:0] action
    output logic        m_tlast
);

    import srsw_pkg::*;

    localparam int ADDR_W = $clog2(SEQ_SPACE);

    logic [CNT_W-1:0]  win_cfg_reg;
    rslt_t             push;
    logic              out_free;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [1:0]        mem_wr_data;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [1:0]        mem_rd_data;
    logic [ADDR_W-1:0] mu_x;
    logic [ADDR_W-1:0] mu_base;
    logic [ADDR_W-1:0] mu_dist;
    logic [ADDR_W-1:0] mu_nxt;

    logic              m_valid_reg;
    logic [1:0]        m_action_reg;
    logic [3:0]        m_seq_reg;
    logic              m_accepted_reg;
    logic [3:0]        m_assigned_reg;
    logic [3:0]        m_outstanding_reg;
    logic              m_last_reg;

    // window size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg <= WIN_RESET;
        end else if (cfg_we) begin
            win_cfg_reg <= cfg_wdata;
        end
    end

    srsw_slot_mem #(
        .DEPTH  (SEQ_SPACE),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .re      (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    srsw_mod_unit #(
        .SEQ_SPACE (SEQ_SPACE),
        .ADDR_W    (ADDR_W)
    ) u_mod (
        .x    (mu_x),
        .base (mu_base),
        .offs (mu_dist),
        .nxt  (mu_nxt)
    );

    srsw_ctrl #(
        .SEQ_SPACE (SEQ_SPACE),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser[1:0]),
        .in_seq      (s_tdata[3:0]),
        .in_ack      (s_tuser[2]),
        .win_cfg     (win_cfg_reg),
        .push        (push),
        .out_free    (out_free),
        .mem_we      (mem_we),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_re      (mem_re),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mu_x        (mu_x),
        .mu_base     (mu_base),
        .mu_dist     (mu_dist),
        .mu_nxt      (mu_nxt)
    );

    // Output register: load a new word when empty or being drained,
    // otherwise hold until the sink takes it.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_action_reg      <= push.action;
            m_seq_reg         <= push.seq_num;
            m_accepted_reg    <= push.accepted;
            m_assigned_reg    <= push.assigned;
            m_outstanding_reg <= push.outstanding;
            m_last_reg        <= push.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_outstanding_reg, m_assigned_reg, m_accepted_reg, m_seq_reg};
    assign m_tuser  = m_action_reg;
    assign m_tlast  = m_last_reg;

    // an accepted word keeps the block busy for at least the next cycle
    `SRSW_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    // outstanding never exceeds the largest window
    `SRSW_NEVER(a_outstanding_max, m_tvalid && (m_tdata[12:9] > 4'd8), "outstanding above 8")
    // a status word is always the only word of its item
    `SRSW_ASSERT(a_status_last, (m_tvalid && (m_tuser == ACT_STATUS)) |-> m_tlast,
        "status not last")
    // a taken submit never stops a timer
    `SRSW_NEVER(a_submit_no_stop, m_tvalid && m_tdata[4] && (m_tuser == ACT_STOP),
        "stop on submit")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import srsw_pkg::*;

    // mode 3 carries no event: the block only slides and sweeps
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam int NSEQ       = SEQ_SPACE_DEF;
    localparam int NUM_DIR    = 25;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 32;
    localparam int TAIL_WAIT  = 48;      // wait after the last expected word is back
    localparam int HOLD_LEN   = 400;     // long receiver back-pressure stretch
    localparam int CYC_LIMIT  = 400000;

    // one result word, fields in the order the block reports them
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] seq;
        logic       accepted;
        logic [3:0] assigned;
        logic [3:0] outstanding;
        logic       last;
    } cmd_word_t;

    // one row of the directed table; the word is used only where typed is set
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] seq;
        logic       ack;
        logic       typed;
        cmd_word_t  word;
    } dir_row_t;

    localparam cmd_word_t NO_WORD = '0;

    localparam dir_row_t DIRECTED [NUM_DIR] = '{
        // nothing written yet: replies, expiries and idle items give a status
        '{MODE_REPLY,  4'd5,  1'b1, 1'b1, '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1}},
        '{MODE_EXPIRE, 4'd15, 1'b0, 1'b1, '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1}},
        '{MODE_NONE,   4'd15, 1'b1, 1'b1, '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1}},
        // first submit takes slot 0 and sends it at once
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b1, '{ACT_XMIT,   4'd0, 1'b1, 4'd0, 4'd1, 1'b1}},
        '{MODE_SUBMIT, 4'd15, 1'b1, 1'b0, NO_WORD},
        // ACK slides the base; a second ACK for the same slot is stale
        '{MODE_REPLY,  4'd0,  1'b1, 1'b0, NO_WORD},
        '{MODE_REPLY,  4'd0,  1'b1, 1'b1, '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd1, 1'b1}},
        // NACK: stop then resend; expiry resends; expiry of an idle slot is stale
        '{MODE_REPLY,  4'd1,  1'b0, 1'b0, NO_WORD},
        '{MODE_EXPIRE, 4'd1,  1'b1, 1'b0, NO_WORD},
        '{MODE_EXPIRE, 4'd9,  1'b0, 1'b0, NO_WORD},
        // fill the window of 8
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        // window full: submit refused, outstanding at its top value
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b1, '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd8, 1'b1}},
        '{MODE_EXPIRE, 4'd4,  1'b0, 1'b0, NO_WORD},
        '{MODE_REPLY,  4'd3,  1'b0, 1'b0, NO_WORD},
        '{MODE_REPLY,  4'd1,  1'b1, 1'b0, NO_WORD},
        '{MODE_REPLY,  4'd8,  1'b1, 1'b0, NO_WORD},
        '{MODE_SUBMIT, 4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_NONE,   4'd0,  1'b0, 1'b0, NO_WORD},
        '{MODE_REPLY,  4'd15, 1'b0, 1'b0, NO_WORD}
    };

    // window register per random phase: extremes, clamped value and shrinks
    localparam logic [3:0] PHASE_WIN [NUM_PHASES] = '{
        4'd15, 4'd1, 4'd0, 4'd3, 4'd8, 4'd2, 4'd6, 4'd8
    };
    // idle bounds per phase, sender then receiver; zero gives back-to-back words
    localparam int PHASE_TX_GAP [NUM_PHASES] = '{15, 0, 15, 15, 0, 15, 0, 15};
    localparam int PHASE_RX_GAP [NUM_PHASES] = '{15, 0, 15, 0, 15, 15, 0, 15};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [3:0] seq_num, [7:4] zero
    logic [2:0]  s_tuser   = '0;   // [1:0] mode, [2] is_ack
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [3:0] seq_num_out, [4] accepted, [8:5] assigned_seq,
                                   // [12:9] outstanding, [15:13] zero
    logic [1:0]  m_tuser;          // [1:0] action
    logic        m_tlast;

    // window state as the testbench sees it
    logic [1:0]  slot_st [NSEQ];
    logic [3:0]  wr_ptr   = '0;
    logic [3:0]  base_ptr = '0;
    logic [3:0]  unacked  = '0;
    logic [3:0]  win_reg  = WIN_RESET;

    cmd_word_t   step_cmds [10];
    int          step_n;
    cmd_word_t   cmds_due [$];

    int          fail_cnt   = 0;
    int          cyc        = 0;
    int          tx_gap_max = 15;
    int          rx_gap_max = 15;
    bit          hold_req   = 1'b0;

    selective_repeat_sender_window i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // watchdog: abort a hung run
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply one accepted input word to the window state and build the
    // command words it should produce in step_cmds[0 .. step_n-1].
    function automatic void predict_window_cmds(logic [1:0] mode, logic [3:0] seq,
                                                logic ack);
        int         win;
        int         steps;
        logic [3:0] idx;
        logic       took;
        logic [3:0] given;
        win   = int'(win_reg);
        if (win > WIN_MAX)
            win = WIN_MAX;
        if (win > NSEQ / 2)
            win = NSEQ / 2;
        step_n = 0;
        took   = 1'b0;
        given  = '0;
        case (mode)
            MODE_SUBMIT: begin
                // take the slot only if the write cursor is inside the window
                if (int'(4'(wr_ptr - base_ptr)) < win) begin
                    slot_st[wr_ptr] = ST_UNSENT;
                    took    = 1'b1;
                    given   = wr_ptr;
                    wr_ptr  = wr_ptr + 4'd1;
                    unacked = unacked + 4'd1;
                end
            end
            MODE_REPLY: begin
                // only a sent slot reacts; stop its timer first
                if (slot_st[seq] == ST_SENT) begin
                    step_cmds[step_n] = '{ACT_STOP, seq, 1'b0, 4'd0, 4'd0, 1'b0};
                    step_n++;
                    if (ack) begin
                        slot_st[seq] = ST_CONF;
                        if (unacked != 0)
                            unacked = unacked - 4'd1;
                    end else begin
                        slot_st[seq] = ST_UNSENT;
                    end
                end
            end
            MODE_EXPIRE: begin
                if (slot_st[seq] == ST_SENT)
                    slot_st[seq] = ST_UNSENT;
            end
            default: ;
        endcase

        // advance the base over confirmed slots, never past the write cursor
        idx   = base_ptr;
        steps = 0;
        while (steps < win && idx != wr_ptr && slot_st[idx] == ST_CONF) begin
            idx = idx + 4'd1;
            steps++;
        end
        base_ptr = idx;

        // send every written, unsent slot inside the window, in window order
        idx   = base_ptr;
        steps = 0;
        while (steps < win && idx != wr_ptr) begin
            if (slot_st[idx] == ST_UNSENT) begin
                slot_st[idx] = ST_SENT;
                step_cmds[step_n] = '{ACT_XMIT, idx, 1'b0, 4'd0, 4'd0, 1'b0};
                step_n++;
            end
            idx = idx + 4'd1;
            steps++;
        end

        if (step_n == 0) begin
            step_cmds[0] = '{ACT_STATUS, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0};
            step_n = 1;
        end
        for (int k = 0; k < step_n; k++) begin
            step_cmds[k].accepted    = took;
            step_cmds[k].assigned    = given;
            step_cmds[k].outstanding = unacked;
            step_cmds[k].last        = (k == step_n - 1);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Offer one word after a random gap, wait for the handshake, then queue
    // its expected commands: the typed word where the table gives one.
    task automatic send_word(input logic [1:0] mode, input logic [3:0] seq,
                             input logic ack, input logic typed, input cmd_word_t word);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {4'b0000, seq};
        s_tuser  <= {ack, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_window_cmds(mode, seq, ack);
        if (typed) begin
            cmds_due.push_back(word);
        end else begin
            for (int k = 0; k < step_n; k++)
                cmds_due.push_back(step_cmds[k]);
        end
    endtask

    // Drop valid, wait until every expected word is back, then let the
    // block finish its last item.
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (cmds_due.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_window(input logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        win_reg = value;
        cfg_we  <= 1'b0;
    endtask

    // result side: random ready gaps, one long hold-off on request
    initial begin : sink
        int        gap;
        cmd_word_t want;
        wait (aresetn);
        forever begin
            gap = $urandom_range(0, rx_gap_max);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_LEN;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            if (cmds_due.size() == 0) begin
                $error("unexpected result word: action %0d seq %0d", m_tuser, m_tdata[3:0]);
                fail_cnt++;
            end else begin
                want = cmds_due.pop_front();
                check_field("action", want.action, m_tuser);
                check_field("seq_num_out", want.seq, m_tdata[3:0]);
                check_field("accepted", want.accepted, m_tdata[4]);
                check_field("assigned_seq", want.assigned, m_tdata[8:5]);
                check_field("outstanding", want.outstanding, m_tdata[12:9]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin : stim
        int         r;
        int         n_sent;
        logic [3:0] sent_list [NSEQ];
        logic [1:0] md;
        logic [3:0] sq;
        logic       ak;

        for (int s = 0; s < NSEQ; s++)
            slot_st[s] = ST_UNSENT;

        // hold reset before the first item
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int d = 0; d < NUM_DIR; d++)
            send_word(DIRECTED[d].mode, DIRECTED[d].seq, DIRECTED[d].ack,
                      DIRECTED[d].typed, DIRECTED[d].word);
        drain(TAIL_WAIT);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_window(PHASE_WIN[ph]);
            tx_gap_max = PHASE_TX_GAP[ph];
            rx_gap_max = PHASE_RX_GAP[ph];
            // stall the result side for a long stretch while items keep coming
            if (ph == 0)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // pause the sender mid-phase until the block has caught up
                if (ph == 3 && k == PHASE_LEN / 2)
                    drain(0);

                n_sent = 0;
                for (int s = 0; s < NSEQ; s++) begin
                    if (slot_st[s] == ST_SENT) begin
                        sent_list[n_sent] = 4'(s);
                        n_sent++;
                    end
                end

                // mostly submits and replies/expiries aimed at sent slots
                r  = $urandom_range(0, 99);
                sq = 4'($urandom_range(0, NSEQ - 1));
                ak = 1'($urandom_range(0, 1));
                if (r < 38) begin
                    md = MODE_SUBMIT;
                end else if (r < 72) begin
                    md = MODE_REPLY;
                    ak = ($urandom_range(0, 3) != 0);
                    if (n_sent > 0)
                        sq = sent_list[$urandom_range(0, n_sent - 1)];
                end else if (r < 86) begin
                    md = MODE_EXPIRE;
                    if (n_sent > 0)
                        sq = sent_list[$urandom_range(0, n_sent - 1)];
                end else begin
                    // noise: any mode at any sequence number
                    md = 2'($urandom_range(0, 3));
                end
                send_word(md, sq, ak, 1'b0, NO_WORD);
            end
            drain(TAIL_WAIT);
        end

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
